// ----- rtl/rsdsb_pkg.sv -----
// Shared types and constants of the RRIP set-dueling replacement unit.
package rsdsb_pkg;

    localparam int SET_IN_W = 11;
    localparam int WAY_IN_W = 4;
    localparam int ADDR_W   = 58;
    localparam int ACC_W    = 8;
    localparam int OUT_W    = 4;
    localparam int RRPV_W   = 2;
    localparam int SCNT_W   = 2;

    localparam logic [ACC_W-1:0]  MASK_RESET = 8'd31;
    localparam logic [RRPV_W-1:0] RRPV_MAX   = 2'd3;
    localparam logic [RRPV_W-1:0] RRPV_LONG  = 2'd2;
    localparam logic [RRPV_W-1:0] RRPV_NEAR  = 2'd0;
    localparam logic [SCNT_W-1:0] SCNT_MAX   = 2'd3;
    localparam logic              FUNC_QUERY = 1'b0;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic last;
        logic rem_zero;
    } div_status_t;

endpackage

// ----- rtl/rsdsb_remdiv.sv -----
// Registered remainder check for leader-set detection by reciprocal multiplication.
module rsdsb_remdiv #(
    parameter int DW      = 11,
    parameter int DIVISOR = 64,
    parameter int QW      = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [DW-1:0]         dividend,
    output rsdsb_pkg::div_status_t status
);

    localparam int          SH    = DW + $clog2(DIVISOR);
    localparam int          PW    = 2 * DW + 1;
    localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

    logic [DW-1:0] num_reg;
    logic [QW-1:0] quo_reg;
    logic          run_reg;
    logic          last_reg;
    logic          zero_reg;
    logic [PW-1:0] prod;
    logic [DW-1:0] back;

    assign prod = PW'(num_reg) * PW'(RECIP);
    assign back = DW'(PW'(quo_reg) * PW'(DIVISOR));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= load;
            last_reg <= run_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            num_reg <= dividend;
        end
        if (run_reg)
        begin
            quo_reg <= QW'(prod >> SH);
        end
        if (last_reg)
        begin
            zero_reg <= (back == num_reg);
        end
    end

    assign status.last     = last_reg;
    assign status.rem_zero = zero_reg;

endmodule

// ----- rtl/rrip_set_dueling_stream_bypass_unit.sv -----
// Top level of the RRIP set-dueling replacement unit with per-set stream detection.
//
// A word is taken when start is high and busy is low; its answer appears on victim_way and
// is_victim for exactly one cycle with done high, and the receiver cannot stall it. The cycle
// in which a word is accepted issues the synchronous read of the set's RRPV row and stream
// record; the remainder unit then registers the quotient by reciprocal multiplication and
// next the compare that finds whether the set is a leader, and the write-back state modifies
// and writes back the row. done is high in the cycle after the write-back, and a new word can
// be accepted in that same cycle, so a word is not taken before the last one is done.
// busy stays high while a word is in flight, so one word is worked on at a time. After reset
// a clearing pass writes every set with busy high; cfg_we is taken at any time.
module rrip_set_dueling_stream_bypass_unit #(
    parameter int NUM_SETS      = 2048,
    parameter int NUM_WAYS      = 16,
    parameter int LEADER_SETS   = 32,
    parameter int SELECTOR_BITS = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               func,
    input  logic [rsdsb_pkg::SET_IN_W-1:0]     set_index,
    input  logic [rsdsb_pkg::WAY_IN_W-1:0]     way_index,
    input  logic [rsdsb_pkg::ADDR_W-1:0]       block_addr,
    input  logic                               was_hit,
    output logic                               done,
    output logic [rsdsb_pkg::OUT_W-1:0]        victim_way,
    output logic                               is_victim,
    input  logic                               cfg_we,
    input  logic [rsdsb_pkg::ACC_W-1:0]        cfg_wdata
);

    localparam int SET_W       = $clog2(NUM_SETS);
    localparam int WAY_W       = $clog2(NUM_WAYS);
    localparam int SPACING_RAW = NUM_SETS / LEADER_SETS;
    localparam int SPACING     = (SPACING_RAW > 0) ? SPACING_RAW : 1;
    localparam int QMAX        = (NUM_SETS - 1) / SPACING;
    localparam int QW          = (QMAX > 0) ? $clog2(QMAX + 1) : 1;
    localparam int SRRIP_LIMIT = SPACING * (LEADER_SETS / 2);
    localparam int MQ          = $clog2(((1 << rsdsb_pkg::SET_IN_W) - 1) / NUM_SETS + 1);
    localparam int META_W      = rsdsb_pkg::SCNT_W + rsdsb_pkg::ADDR_W;
    localparam logic [SELECTOR_BITS-1:0] SEL_MID = SELECTOR_BITS'(1 << (SELECTOR_BITS - 1));
    localparam logic [SELECTOR_BITS-1:0] SEL_MAX = '1;

    typedef logic [NUM_WAYS-1:0][rsdsb_pkg::RRPV_W-1:0] row_t;

    rsdsb_pkg::state_t state_reg;
    rsdsb_pkg::state_t state_next;

    logic [SET_W-1:0]                clr_reg;
    logic [SET_W-1:0]                set_reg;
    logic [rsdsb_pkg::WAY_IN_W-1:0]  way_reg;
    logic [rsdsb_pkg::ADDR_W-1:0]    addr_reg;
    logic                            hit_reg;
    logic                            func_reg;
    logic [SELECTOR_BITS-1:0]        sel_reg;
    logic [SELECTOR_BITS-1:0]        sel_next;
    logic [rsdsb_pkg::ACC_W-1:0]     acc_reg;
    logic [rsdsb_pkg::ACC_W-1:0]     acc_next;
    logic [rsdsb_pkg::ACC_W-1:0]     mask_reg;
    logic                            done_reg;
    logic [rsdsb_pkg::OUT_W-1:0]     victim_way_reg;
    logic                            is_victim_reg;

    row_t                            rrpv_mem [NUM_SETS];
    logic [META_W-1:0]               meta_mem [NUM_SETS];
    row_t                            rrpv_rd_reg;
    logic [META_W-1:0]               meta_rd_reg;

    logic                            accept;
    logic [rsdsb_pkg::SET_IN_W-1:0]  set_mod;
    logic [SET_W-1:0]                set_in;
    logic                            mem_we;
    logic [SET_W-1:0]                wr_addr;
    row_t                            rrpv_wdata;
    logic [META_W-1:0]               meta_wdata;
    rsdsb_pkg::div_status_t          div_st;

    row_t                            aged;
    logic                            found1;
    logic                            found2;
    logic [WAY_W-1:0]                v1;
    logic [WAY_W-1:0]                v2;
    logic [WAY_W-1:0]                victim;
    row_t                            exec_row;
    logic [META_W-1:0]               exec_meta;
    logic [rsdsb_pkg::SCNT_W-1:0]    cnt_old;
    logic [rsdsb_pkg::SCNT_W-1:0]    cnt_new;
    logic [rsdsb_pkg::ADDR_W-1:0]    last_old;
    logic                            near;
    logic                            way_ok;
    logic                            streaming;
    logic                            leader;
    logic                            srrip_leader;
    logic                            brrip;
    logic [rsdsb_pkg::RRPV_W-1:0]    ins;
    logic [rsdsb_pkg::RRPV_W-1:0]    new_rrpv;

    assign accept = (state_reg == rsdsb_pkg::ST_IDLE) && start;
    assign busy   = (state_reg != rsdsb_pkg::ST_IDLE);

    always_comb
    begin
        set_mod = set_index;
        for (int k = MQ - 1; k >= 0; k--)
        begin
            if (int'(set_mod) >= (NUM_SETS << k))
            begin
                set_mod = set_mod - rsdsb_pkg::SET_IN_W'(NUM_SETS << k);
            end
        end
    end

    assign set_in = SET_W'(set_mod);

    rsdsb_remdiv #(
        .DW      (SET_W),
        .DIVISOR (SPACING),
        .QW      (QW)
    ) u_remdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .dividend (set_in),
        .status   (div_st)
    );

    always_comb
    begin
        found1 = 1'b0;
        found2 = 1'b0;
        v1     = '0;
        v2     = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            aged[w] = (rrpv_rd_reg[w] == rsdsb_pkg::RRPV_MAX) ? rsdsb_pkg::RRPV_MAX
                                                               : rrpv_rd_reg[w] + 2'd1;
            if (rrpv_rd_reg[w] == rsdsb_pkg::RRPV_MAX)
            begin
                found1 = 1'b1;
                v1     = WAY_W'(w);
            end
            if (aged[w] == rsdsb_pkg::RRPV_MAX)
            begin
                found2 = 1'b1;
                v2     = WAY_W'(w);
            end
        end
        victim = found1 ? v1 : (found2 ? v2 : '0);
    end

    always_comb
    begin
        cnt_old  = meta_rd_reg[META_W-1 -: rsdsb_pkg::SCNT_W];
        last_old = meta_rd_reg[rsdsb_pkg::ADDR_W-1:0];
        near     = (addr_reg == last_old)
                || ((last_old != '1) && (addr_reg == last_old + 1'b1))
                || ((addr_reg != '1) && (last_old == addr_reg + 1'b1));
        cnt_new  = cnt_old;
        if (last_old != '0)
        begin
            if (near)
            begin
                if (cnt_old != rsdsb_pkg::SCNT_MAX)
                begin
                    cnt_new = cnt_old + 2'd1;
                end
            end
            else if (cnt_old != '0)
            begin
                cnt_new = cnt_old - 2'd1;
            end
        end

        acc_next     = acc_reg + 1'b1;
        way_ok       = int'(way_reg) < NUM_WAYS;
        streaming    = (cnt_new == rsdsb_pkg::SCNT_MAX);
        leader       = div_st.rem_zero;
        srrip_leader = leader && (int'(set_reg) < SRRIP_LIMIT);
        brrip        = leader ? !srrip_leader : (sel_reg >= SEL_MID);
        if (brrip)
        begin
            ins = ((acc_next & mask_reg) == '0) ? rsdsb_pkg::RRPV_LONG : rsdsb_pkg::RRPV_NEAR;
        end
        else
        begin
            ins = rsdsb_pkg::RRPV_LONG;
        end

        if (hit_reg)
        begin
            new_rrpv = rsdsb_pkg::RRPV_NEAR;
        end
        else if (streaming)
        begin
            new_rrpv = rsdsb_pkg::RRPV_MAX;
        end
        else
        begin
            new_rrpv = ins;
        end

        sel_next = sel_reg;
        if (!hit_reg && !streaming && leader)
        begin
            if (srrip_leader)
            begin
                if (sel_reg != SEL_MAX)
                begin
                    sel_next = sel_reg + 1'b1;
                end
            end
            else if (sel_reg != '0)
            begin
                sel_next = sel_reg - 1'b1;
            end
        end

        if (func_reg == rsdsb_pkg::FUNC_QUERY)
        begin
            exec_row  = found1 ? rrpv_rd_reg : aged;
            exec_meta = meta_rd_reg;
        end
        else
        begin
            exec_row = rrpv_rd_reg;
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                if (way_ok && (int'(way_reg) == w))
                begin
                    exec_row[w] = new_rrpv;
                end
            end
            exec_meta = {cnt_new, addr_reg};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        wr_addr    = set_reg;
        rrpv_wdata = exec_row;
        meta_wdata = exec_meta;
        unique case (state_reg)
            rsdsb_pkg::ST_CLEAR:
            begin
                mem_we     = 1'b1;
                wr_addr    = clr_reg;
                rrpv_wdata = {NUM_WAYS{rsdsb_pkg::RRPV_MAX}};
                meta_wdata = '0;
                if (clr_reg == SET_W'(NUM_SETS - 1))
                begin
                    state_next = rsdsb_pkg::ST_IDLE;
                end
            end
            rsdsb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = rsdsb_pkg::ST_DIV;
                end
            end
            rsdsb_pkg::ST_DIV:
            begin
                if (div_st.last)
                begin
                    state_next = rsdsb_pkg::ST_EXEC;
                end
            end
            rsdsb_pkg::ST_EXEC:
            begin
                mem_we     = 1'b1;
                state_next = rsdsb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rsdsb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rsdsb_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            sel_reg  <= SEL_MID;
            acc_reg  <= '0;
            mask_reg <= rsdsb_pkg::MASK_RESET;
            done_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == rsdsb_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_we)
            begin
                mask_reg <= cfg_wdata;
            end
            if ((state_reg == rsdsb_pkg::ST_EXEC) && (func_reg != rsdsb_pkg::FUNC_QUERY))
            begin
                sel_reg <= sel_next;
                acc_reg <= acc_next;
            end
            done_reg <= (state_reg == rsdsb_pkg::ST_EXEC);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg  <= set_in;
            way_reg  <= way_index;
            addr_reg <= block_addr;
            hit_reg  <= was_hit;
            func_reg <= func;
        end
        if (state_reg == rsdsb_pkg::ST_EXEC)
        begin
            is_victim_reg <= (func_reg == rsdsb_pkg::FUNC_QUERY);
            victim_way_reg <= (func_reg == rsdsb_pkg::FUNC_QUERY) ? rsdsb_pkg::OUT_W'(victim)
                                                                  : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rrpv_mem[wr_addr] <= rrpv_wdata;
            meta_mem[wr_addr] <= meta_wdata;
        end
        if (accept)
        begin
            rrpv_rd_reg <= rrpv_mem[set_in];
            meta_rd_reg <= meta_mem[set_in];
        end
    end

    assign done       = done_reg;
    assign victim_way = victim_way_reg;
    assign is_victim  = is_victim_reg;

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == rsdsb_pkg::ST_EXEC))
        else $error("done without a write-back cycle");

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == rsdsb_pkg::ST_IDLE))
        else $error("done while a word is still in flight");

    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == rsdsb_pkg::ST_DIV))
        else $error("accepted word did not enter the remainder phase");

    a_sel_moves_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (sel_reg != $past(sel_reg)) |-> $past(state_reg == rsdsb_pkg::ST_EXEC))
        else $error("selector moved outside write-back");

    a_acc_moves_on_update: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg != $past(acc_reg)) |-> $past(state_reg == rsdsb_pkg::ST_EXEC && func_reg))
        else $error("access count moved without an update");

endmodule

// ----- bench/rrip_answer_checker.sv -----
// Checker for the RRIP replacement unit: tracks its words, predicts each answer and compares.
module rrip_answer_checker #(
    parameter int NUM_SETS      = 2048,
    parameter int NUM_WAYS      = 16,
    parameter int LEADER_SETS   = 32,
    parameter int SELECTOR_BITS = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic                           func,
    input  logic [rsdsb_pkg::SET_IN_W-1:0] set_index,
    input  logic [rsdsb_pkg::WAY_IN_W-1:0] way_index,
    input  logic [rsdsb_pkg::ADDR_W-1:0]   block_addr,
    input  logic                           was_hit,
    input  logic                           done,
    input  logic [rsdsb_pkg::OUT_W-1:0]    victim_way,
    input  logic                           is_victim,
    input  logic                           cfg_we,
    input  logic [rsdsb_pkg::ACC_W-1:0]    cfg_wdata,
    output int                             fail_count,
    output int                             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SPACING = (NUM_SETS / LEADER_SETS) > 0 ? (NUM_SETS / LEADER_SETS) : 1;
    localparam int SEL_MID = 1 << (SELECTOR_BITS - 1);
    localparam int SEL_MAX = (1 << SELECTOR_BITS) - 1;

    typedef struct packed {
        logic [rsdsb_pkg::OUT_W-1:0] way;
        logic                        victim;
    } answer_t;

    logic [rsdsb_pkg::RRPV_W-1:0] rrpv_q     [NUM_SETS][NUM_WAYS];
    logic [rsdsb_pkg::SCNT_W-1:0] scnt_q     [NUM_SETS];
    logic [rsdsb_pkg::ADDR_W-1:0] last_blk   [NUM_SETS];
    int                           selector;
    logic [rsdsb_pkg::ACC_W-1:0]  access_cnt;
    logic [rsdsb_pkg::ACC_W-1:0]  rare_mask;
    answer_t                      pending_answers [$];

    function automatic logic [rsdsb_pkg::OUT_W-1:0] answer_query(input int unsigned s);
        int w;
        for (w = 0; w < NUM_WAYS; w++)
            if (rrpv_q[s][w] == rsdsb_pkg::RRPV_MAX)
                return w[rsdsb_pkg::OUT_W-1:0];
        for (w = 0; w < NUM_WAYS; w++)
            if (rrpv_q[s][w] != rsdsb_pkg::RRPV_MAX)
                rrpv_q[s][w] = rrpv_q[s][w] + 1'b1;
        for (w = 0; w < NUM_WAYS; w++)
            if (rrpv_q[s][w] == rsdsb_pkg::RRPV_MAX)
                return w[rsdsb_pkg::OUT_W-1:0];
        return '0;
    endfunction

    task automatic apply_access(input int unsigned s, input int unsigned w,
                                input logic [rsdsb_pkg::ADDR_W-1:0] a, input logic hit);
        logic [rsdsb_pkg::ADDR_W-1:0] delta;
        logic                         way_ok;
        logic                         lead;
        logic                         srrip_lead;
        logic                         pick_brrip;
        logic [rsdsb_pkg::RRPV_W-1:0] ins;
        way_ok     = w < NUM_WAYS;
        srrip_lead = 1'b0;
        access_cnt = access_cnt + 1'b1;
        if (last_blk[s] != '0)
        begin
            delta = (a > last_blk[s]) ? a - last_blk[s] : last_blk[s] - a;
            if (delta <= 1)
            begin
                if (scnt_q[s] != rsdsb_pkg::SCNT_MAX)
                    scnt_q[s] = scnt_q[s] + 1'b1;
            end
            else if (scnt_q[s] != '0)
                scnt_q[s] = scnt_q[s] - 1'b1;
        end
        last_blk[s] = a;
        if (hit)
        begin
            if (way_ok)
                rrpv_q[s][w] = rsdsb_pkg::RRPV_NEAR;
            return;
        end
        // streaming set: insert distant, leave the selector alone
        if (scnt_q[s] == rsdsb_pkg::SCNT_MAX)
        begin
            if (way_ok)
                rrpv_q[s][w] = rsdsb_pkg::RRPV_MAX;
            return;
        end
        lead = (s % SPACING) == 0;
        if (lead)
        begin
            srrip_lead = (s / SPACING) < (LEADER_SETS / 2);
            pick_brrip = !srrip_lead;
        end
        else
            pick_brrip = selector >= SEL_MID;
        if (pick_brrip)
            ins = ((access_cnt & rare_mask) == '0) ? rsdsb_pkg::RRPV_LONG
                                                   : rsdsb_pkg::RRPV_NEAR;
        else
            ins = rsdsb_pkg::RRPV_LONG;
        if (way_ok)
            rrpv_q[s][w] = ins;
        if (lead)
        begin
            if (srrip_lead)
            begin
                if (selector < SEL_MAX)
                    selector = selector + 1;
            end
            else if (selector > 0)
                selector = selector - 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        answer_t     want;
        int unsigned s;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SETS; i++)
            begin
                for (int j = 0; j < NUM_WAYS; j++)
                    rrpv_q[i][j] = rsdsb_pkg::RRPV_MAX;
                scnt_q[i]   = '0;
                last_blk[i] = '0;
            end
            selector   = SEL_MID;
            access_cnt = '0;
            rare_mask  = rsdsb_pkg::MASK_RESET;
            pending_answers.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_answers.size() == 0)
                begin
                    $error("answer with no word outstanding: victim_way %0d is_victim %0d",
                           victim_way, is_victim);
                    fail_count++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (victim_way !== want.way)
                    begin
                        $error("victim_way expected %0d actual %0d", want.way, victim_way);
                        fail_count++;
                    end
                    if (is_victim !== want.victim)
                    begin
                        $error("is_victim expected %0d actual %0d", want.victim, is_victim);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
                rare_mask = cfg_wdata;
            if (start && !busy)
            begin
                s = set_index % NUM_SETS;
                if (func == rsdsb_pkg::FUNC_QUERY)
                begin
                    want.way    = answer_query(s);
                    want.victim = 1'b1;
                end
                else
                begin
                    apply_access(s, way_index, block_addr, was_hit);
                    want.way    = '0;
                    want.victim = 1'b0;
                end
                pending_answers.push_back(want);
            end
            outstanding = pending_answers.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
// Top of the testbench: clock, reset and stimulus for the RRIP replacement unit, and the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   NUM_SETS        = 2048;
    localparam int   NUM_WAYS        = 16;
    localparam int   LEADER_SETS     = 32;
    localparam int   SELECTOR_BITS   = 10;
    localparam int   SPACING         = NUM_SETS / LEADER_SETS;
    localparam int   CYCLE_LIMIT     = 300000;
    localparam int   WORDS_PER_PHASE = 440;
    localparam int   SETTLE          = 8;
    localparam logic FUNC_UPDATE     = ~rsdsb_pkg::FUNC_QUERY;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic                           func;
    logic [rsdsb_pkg::SET_IN_W-1:0] set_index;
    logic [rsdsb_pkg::WAY_IN_W-1:0] way_index;
    logic [rsdsb_pkg::ADDR_W-1:0]   block_addr;
    logic                           was_hit;
    logic                           done;
    logic [rsdsb_pkg::OUT_W-1:0]    victim_way;
    logic                           is_victim;
    logic                           cfg_we;
    logic [rsdsb_pkg::ACC_W-1:0]    cfg_wdata;
    int                             fail_count;
    int                             outstanding;
    int                             cycle_cnt;
    int                             words_sent;
    int                             calm_left;
    logic                           lean_srrip;

    rrip_set_dueling_stream_bypass_unit #(
        .NUM_SETS      (NUM_SETS),
        .NUM_WAYS      (NUM_WAYS),
        .LEADER_SETS   (LEADER_SETS),
        .SELECTOR_BITS (SELECTOR_BITS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .set_index  (set_index),
        .way_index  (way_index),
        .block_addr (block_addr),
        .was_hit    (was_hit),
        .done       (done),
        .victim_way (victim_way),
        .is_victim  (is_victim),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    rrip_answer_checker #(
        .NUM_SETS      (NUM_SETS),
        .NUM_WAYS      (NUM_WAYS),
        .LEADER_SETS   (LEADER_SETS),
        .SELECTOR_BITS (SELECTOR_BITS)
    ) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .set_index   (set_index),
        .way_index   (way_index),
        .block_addr  (block_addr),
        .was_hit     (was_hit),
        .done        (done),
        .victim_way  (victim_way),
        .is_victim   (is_victim),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt >= CYCLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic logic [rsdsb_pkg::ADDR_W-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[rsdsb_pkg::ADDR_W-1:0];
    endfunction

    function automatic logic [rsdsb_pkg::SET_IN_W-1:0] pick_set();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 28)
        begin
            // favored leader kind most of the time, to walk the selector
            if ((r < 20) == lean_srrip)
                v = SPACING * $urandom_range(0, LEADER_SETS / 2 - 1);
            else
                v = SPACING * $urandom_range(LEADER_SETS / 2, LEADER_SETS - 1);
        end
        else if (r < 90)
        begin
            case ($urandom_range(0, 7))
                0: v = 5;
                1: v = 7;
                2: v = 100;
                3: v = 300;
                4: v = 777;
                5: v = 1500;
                6: v = 2000;
                default: v = NUM_SETS - 1;
            endcase
        end
        else
            v = $urandom_range(0, NUM_SETS - 1);
        return v[rsdsb_pkg::SET_IN_W-1:0];
    endfunction

    task automatic send_word(input logic f, input logic [rsdsb_pkg::SET_IN_W-1:0] s,
                             input logic [rsdsb_pkg::WAY_IN_W-1:0] w,
                             input logic [rsdsb_pkg::ADDR_W-1:0] a,
                             input logic h);
        int   gap;
        logic taken;
        if (calm_left > 0)
        begin
            calm_left--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 29) == 0)
                calm_left = $urandom_range(10, 40);
            gap = $urandom_range(0, 16);
        end
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        func       = f;
        set_index  = s;
        way_index  = w;
        block_addr = a;
        was_hit    = h;
        start      = 1'b1;
        do
        begin
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic query_set(input logic [rsdsb_pkg::SET_IN_W-1:0] s);
        send_word(rsdsb_pkg::FUNC_QUERY, s, rsdsb_pkg::WAY_IN_W'($urandom), rand_addr(),
                  1'($urandom));
    endtask

    initial
    begin
        int                             pick;
        int                             phase_end;
        int                             n;
        logic [rsdsb_pkg::SET_IN_W-1:0] s;
        logic [rsdsb_pkg::ADDR_W-1:0]   a;

        rst_n      = 1'b0;
        start      = 1'b0;
        func       = rsdsb_pkg::FUNC_QUERY;
        set_index  = '0;
        way_index  = '0;
        block_addr = '0;
        was_hit    = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        words_sent = 0;
        calm_left  = 0;
        lean_srrip = 1'b1;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        query_set('0);
        send_word(FUNC_UPDATE, '0, '0, '1, 1'b1);
        query_set('0);
        send_word(FUNC_UPDATE, '1, '1, '0, 1'b1);
        send_word(FUNC_UPDATE, '1, '1, rsdsb_pkg::ADDR_W'(1), 1'b0);
        for (int k = 0; k < 4; k++)
            send_word(FUNC_UPDATE, rsdsb_pkg::SET_IN_W'(5), rsdsb_pkg::WAY_IN_W'(3 + k),
                      rsdsb_pkg::ADDR_W'(1000 + (k + 1) / 2), 1'b0);
        query_set(rsdsb_pkg::SET_IN_W'(5));
        send_word(FUNC_UPDATE, rsdsb_pkg::SET_IN_W'(NUM_SETS / 2), rsdsb_pkg::WAY_IN_W'(2),
                  rand_addr(), 1'b0);
        send_word(FUNC_UPDATE, '0, rsdsb_pkg::WAY_IN_W'(3), rand_addr(), 1'b0);
        send_word(FUNC_UPDATE, rsdsb_pkg::SET_IN_W'(100), '0, rand_addr(), 1'b0);
        query_set('1);
        query_set(rsdsb_pkg::SET_IN_W'(100));

        for (int ph = 0; ph < 4; ph++)
        begin
            start = 1'b0;
            while (outstanding != 0)
                @(negedge clk);
            repeat (SETTLE) @(negedge clk);
            case (ph)
                0: cfg_wdata = '0;
                1: cfg_wdata = '1;
                2: cfg_wdata = rsdsb_pkg::ACC_W'($urandom);
                default: cfg_wdata = rsdsb_pkg::MASK_RESET;
            endcase
            cfg_we = 1'b1;
            @(negedge clk);
            cfg_we     = 1'b0;
            lean_srrip = (ph % 2) == 0;
            phase_end  = words_sent + WORDS_PER_PHASE;
            while (words_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                s    = pick_set();
                if (pick < 30)
                begin
                    // run of neighboring blocks, sometimes broken
                    a = rand_addr();
                    n = $urandom_range(4, 12);
                    repeat (n)
                    begin
                        send_word(FUNC_UPDATE, s, rsdsb_pkg::WAY_IN_W'($urandom), a,
                                  $urandom_range(0, 3) == 0);
                        if ($urandom_range(0, 9) == 0)
                            a = rand_addr();
                        else if ($urandom_range(0, 4) == 0)
                            a = a - 1'b1;
                        else
                            a = a + $urandom_range(0, 1);
                    end
                    if ($urandom_range(0, 1) == 1)
                        query_set(s);
                end
                else if (pick < 45)
                begin
                    // touch every way, then age the set with queries
                    for (int w = 0; w < NUM_WAYS; w++)
                        send_word(FUNC_UPDATE, s, rsdsb_pkg::WAY_IN_W'(w), rand_addr(),
                                  $urandom_range(0, 3) != 0);
                    n = $urandom_range(1, 3);
                    repeat (n) query_set(s);
                end
                else if (pick < 65)
                    query_set(s);
                else if (pick < 88)
                    send_word(FUNC_UPDATE, s, rsdsb_pkg::WAY_IN_W'($urandom), rand_addr(),
                              $urandom_range(0, 3) == 0);
                else
                    send_word(1'($urandom), rsdsb_pkg::SET_IN_W'($urandom),
                              rsdsb_pkg::WAY_IN_W'($urandom), rand_addr(), 1'($urandom));
            end
        end

        start = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
